FILE: rtl/ncc_pkg.sv
// ---------------------------------------------------------------------------
// Nearest centroid classifier package
// Shared sizes, operation and status codes, and the request record that
// travels down the chain of class cells.
// ---------------------------------------------------------------------------
package ncc_pkg;

  // Table size: one cell per class slot, one stored element per band.
  localparam int NUM_CLASSES = 16;
  localparam int NUM_BANDS   = 8;

  // Fixed field widths of the request and result.
  localparam int SLOT_W  = 4;
  localparam int BAND_W  = 3;
  localparam int DATA_W  = 16;
  localparam int SQ_W    = 34;
  localparam int DIST_W  = 35;
  localparam int CFG_W   = 4;
  localparam int STAT_W  = 2;

  // Largest usable band count and the value the band register resets to.
  localparam logic [CFG_W-1:0] BANDS_LIMIT = (NUM_BANDS < 8) ? CFG_W'(NUM_BANDS) : CFG_W'(8);
  localparam logic [CFG_W-1:0] BANDS_RESET = CFG_W'(8);

  // Operation codes on the request channel.
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_RETIRE = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_BAD_PIX  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NO_CLASS = 2'd2;

  // Request record handed from cell to cell. The best-match fields collect
  // the running minimum; sq carries a cell's own square to its second stage.
  typedef struct packed {
    logic                     is_wr;
    logic                     is_ret;
    logic                     is_smp;
    logic [SLOT_W-1:0]        slot;
    logic signed [DATA_W-1:0] label;
    logic [BAND_W-1:0]        band;
    logic signed [DATA_W-1:0] value;
    logic                     smp_ok;
    logic                     first;
    logic                     last;
    logic                     bad;
    logic                     found;
    logic signed [DATA_W-1:0] best_label;
    logic [DIST_W-1:0]        best_dist;
    logic [SQ_W-1:0]          sq;
  } req_t;

endpackage

FILE: rtl/ncc_cell.sv
// ---------------------------------------------------------------------------
// Nearest centroid class cell
// Holds one class slot (centroid vector, label, in-use flag, running
// distance). Stage one squares the difference, stage two accumulates and
// updates the running minimum before handing the request on.
// ---------------------------------------------------------------------------
module ncc_cell
  import ncc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [SLOT_W-1:0] cell_id,
  input  logic              in_vld,
  input  req_t              in_req,
  output logic              out_vld,
  output req_t              out_req
);

  logic signed [DATA_W-1:0] cent_r [NUM_BANDS];
  logic signed [DATA_W-1:0] label_r;
  logic                     use_r;
  logic [DIST_W-1:0]        acc_r;

  logic mid_vld_r;
  req_t mid_req_r;
  logic out_vld_r;
  req_t out_req_r;

  logic                     hit_a;
  logic signed [DATA_W-1:0] cent_rd;
  logic signed [DATA_W:0]   diff;
  logic signed [SQ_W-1:0]   prod;
  req_t                     req_a_nxt;

  logic                     hit_b;
  logic [DIST_W-1:0]        acc_base;
  logic [DIST_W:0]          sum;
  logic [DIST_W-1:0]        acc_nxt;
  logic                     better;
  req_t                     req_b_nxt;

  // Stage one: fetch this slot's element for the band and square the difference.
  always_comb begin
    hit_a     = in_req.slot == cell_id;
    cent_rd   = cent_r[in_req.band];
    diff      = {in_req.value[DATA_W-1], in_req.value} - {cent_rd[DATA_W-1], cent_rd};
    prod      = diff * diff;
    req_a_nxt = in_req;
    req_a_nxt.sq = prod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_vld_r <= 1'b0;
    end else if (adv) begin
      mid_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mid_req_r <= req_a_nxt;
      if (in_vld && in_req.is_wr && hit_a) begin
        cent_r[in_req.band] <= in_req.value;
      end
    end
  end

  // Stage two: accumulate with saturation and fold into the running minimum.
  always_comb begin
    hit_b    = mid_req_r.slot == cell_id;
    acc_base = mid_req_r.first ? '0 : acc_r;
    sum      = {1'b0, acc_base} +
               {{(DIST_W + 1 - SQ_W){1'b0}}, (mid_req_r.smp_ok ? mid_req_r.sq : {SQ_W{1'b0}})};
    acc_nxt  = sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];
    better   = use_r && (!mid_req_r.found || (acc_nxt < mid_req_r.best_dist));
    req_b_nxt = mid_req_r;
    if (mid_req_r.is_smp && mid_req_r.last && better) begin
      req_b_nxt.found      = 1'b1;
      req_b_nxt.best_dist  = acc_nxt;
      req_b_nxt.best_label = label_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      use_r     <= 1'b0;
      acc_r     <= '0;
    end else if (adv) begin
      out_vld_r <= mid_vld_r;
      if (mid_vld_r) begin
        if (mid_req_r.is_wr && hit_b) begin
          use_r <= 1'b1;
        end else if (mid_req_r.is_ret && hit_b) begin
          use_r <= 1'b0;
        end
        if (mid_req_r.is_smp) begin
          acc_r <= acc_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_req_r <= req_b_nxt;
      if (mid_vld_r && mid_req_r.is_wr && hit_b) begin
        label_r <= mid_req_r.label;
      end
    end
  end

  assign out_vld = out_vld_r;
  assign out_req = out_req_r;

endmodule

FILE: rtl/nearest_centroid_classifier_unit.sv
// ---------------------------------------------------------------------------
// Nearest centroid classifier unit
// Minimum-distance pixel classifier over a chain of class cells.
// ---------------------------------------------------------------------------
// Takes one request per cycle: a centroid element write, a slot retire, or
// one band sample of a pixel. Every request walks a chain of 16 class cells,
// two register stages per cell, then enters the output register, and a new
// request is taken every cycle while the output side keeps up. The whole
// chain holds while the output register is full and stalled. The user must
// write the band count register only while no request is in flight; the
// block does not enforce this.
module nearest_centroid_classifier_unit
  import ncc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CFG_W-1:0]         cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_op,
  input  logic [SLOT_W-1:0]        in_slot,
  input  logic signed [DATA_W-1:0] in_label,
  input  logic [BAND_W-1:0]        in_band,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_sample_valid,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_class_label,
  output logic [STAT_W-1:0]        out_status,
  output logic [DIST_W-1:0]        out_min_distance
);

  logic [CFG_W-1:0] bands_r;
  logic             bad_r;
  logic             bad_nxt;
  logic             adv;
  logic             take;
  logic [CFG_W-1:0] nb;
  logic             smp_in_range;
  logic             keep;

  logic chain_vld [NUM_CLASSES+1];
  req_t chain_req [NUM_CLASSES+1];

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_label_r;
  logic [STAT_W-1:0]        out_status_r;
  logic [DIST_W-1:0]        out_dist_r;
  req_t                     tail;
  logic                     tail_res;

  // The chain moves whenever the output register can take what reaches it.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign take     = in_valid && adv;

  // Band count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bands_r <= BANDS_RESET;
    end else if (cfg_wr_en) begin
      bands_r <= cfg_wr_data;
    end
  end

  // Clamp the band count and screen requests that have no effect.
  always_comb begin
    if (bands_r == '0) begin
      nb = CFG_W'(1);
    end else if (bands_r > BANDS_LIMIT) begin
      nb = BANDS_LIMIT;
    end else begin
      nb = bands_r;
    end
    smp_in_range = {1'b0, in_band} < nb;
    keep = (in_op == OP_WRITE && {1'b0, in_band} < CFG_W'(NUM_BANDS)) ||
           (in_op == OP_RETIRE) ||
           (in_op == OP_SAMPLE && smp_in_range);
    bad_nxt = ((in_band == '0) ? 1'b0 : bad_r) || !in_sample_valid;
  end

  // Invalid-sample flag for the pixel in progress.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_r <= 1'b0;
    end else if (take && in_op == OP_SAMPLE && smp_in_range) begin
      bad_r <= bad_nxt;
    end
  end

  // Build the request that enters the first cell.
  always_comb begin
    chain_vld[0]            = take && keep;
    chain_req[0].is_wr      = in_op == OP_WRITE;
    chain_req[0].is_ret     = in_op == OP_RETIRE;
    chain_req[0].is_smp     = in_op == OP_SAMPLE;
    chain_req[0].slot       = in_slot;
    chain_req[0].label      = in_label;
    chain_req[0].band       = in_band;
    chain_req[0].value      = in_value;
    chain_req[0].smp_ok     = in_sample_valid;
    chain_req[0].first      = in_band == '0;
    chain_req[0].last       = {1'b0, in_band} == (nb - CFG_W'(1));
    chain_req[0].bad        = bad_nxt;
    chain_req[0].found      = 1'b0;
    chain_req[0].best_label = '0;
    chain_req[0].best_dist  = '0;
    chain_req[0].sq         = '0;
  end

  // Row of class cells, one per slot.
  for (genvar i = 0; i < NUM_CLASSES; i++) begin : g_cell
    ncc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .cell_id (SLOT_W'(i)),
      .in_vld  (chain_vld[i]),
      .in_req  (chain_req[i]),
      .out_vld (chain_vld[i+1]),
      .out_req (chain_req[i+1])
    );
  end

  assign tail     = chain_req[NUM_CLASSES];
  assign tail_res = chain_vld[NUM_CLASSES] && tail.is_smp && tail.last;

  // Output register: form the result of a completed pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tail_res;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (tail.bad) begin
        out_status_r <= STATUS_BAD_PIX;
        out_label_r  <= '0;
        out_dist_r   <= '0;
      end else if (!tail.found) begin
        out_status_r <= STATUS_NO_CLASS;
        out_label_r  <= '0;
        out_dist_r   <= '0;
      end else begin
        out_status_r <= STATUS_OK;
        out_label_r  <= tail.best_label;
        out_dist_r   <= tail.best_dist;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_class_label  = out_label_r;
  assign out_status       = out_status_r;
  assign out_min_distance = out_dist_r;

endmodule

FILE: tb/sv/nearest_centroid_classifier_unit_tb.sv
// ---------------------------------------------------------------------------
// Nearest centroid classifier unit testbench
// Loads a class table, then runs a short table of hand-checked requests and a
// long random stream of pixels, table writes and retires across several band
// counts. Every accepted request goes through a behavioral classifier kept
// here, and each result is matched field by field against the oldest one it
// predicts. Both channels idle at random, and the output side holds off for a
// long stretch at least once.
// ---------------------------------------------------------------------------
module nearest_centroid_classifier_unit_tb;
  import ncc_pkg::*;

  localparam logic [1:0]       OP_UNUSED      = 2'd3;
  localparam logic [CFG_W-1:0] BANDS_AT_RESET = 4'd8;
  localparam longint           DIST_SAT       = 64'h7_FFFF_FFFF;
  localparam int               DRAIN_CYCLES   = 40;
  localparam int               CYCLE_LIMIT    = 250000;
  localparam int               HOLD_CYCLES    = 400;
  localparam int               NUM_PHASES     = 9;
  localparam int               PHASE_REQS     = 140;

  // One request as it is offered on the input channel.
  typedef struct packed {
    logic [1:0]               op;
    logic [SLOT_W-1:0]        slot;
    logic signed [DATA_W-1:0] label;
    logic [BAND_W-1:0]        band;
    logic signed [DATA_W-1:0] value;
    logic                     sample_ok;
  } cls_req_t;

  // One classification as it leaves the block.
  typedef struct packed {
    logic signed [DATA_W-1:0] label;
    logic [STAT_W-1:0]        status;
    logic [DIST_W-1:0]        min_dist;
  } class_result_t;

  // A row of the directed table: a band-count change or a request, the
  // latter with an optional hand-computed result.
  typedef struct packed {
    logic             is_cfg;
    logic [CFG_W-1:0] cfg_val;
    cls_req_t         req;
    logic             typed;
    class_result_t    res;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]         cfg_wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_op = '0;
  logic [SLOT_W-1:0]        in_slot = '0;
  logic signed [DATA_W-1:0] in_label = '0;
  logic [BAND_W-1:0]        in_band = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     in_sample_valid = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_class_label;
  logic [STAT_W-1:0]        out_status;
  logic [DIST_W-1:0]        out_min_distance;

  // Behavioral copy of the class table, running sums and band count.
  logic signed [DATA_W-1:0] centroid [NUM_CLASSES][NUM_BANDS];
  logic signed [DATA_W-1:0] slot_lbl [NUM_CLASSES];
  logic                     slot_used [NUM_CLASSES];
  longint                   dist_acc [NUM_CLASSES];
  logic                     pix_bad;
  logic [CFG_W-1:0]         bands_reg;

  class_result_t pending_class_q [$];
  dir_row_t      dir_q [$];
  class_result_t popped;
  int            fail_cnt = 0;
  int            useful_reqs = 0;
  int            n_ok = 0;
  int            n_bad = 0;
  int            n_none = 0;
  int            cycle_cnt = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  logic          hold_off = 1'b0;
  bit            hold_go = 1'b0;

  logic [CFG_W-1:0] phase_bands [NUM_PHASES] = '{4'd8, 4'd3, 4'd1, 4'd5, 4'd0, 4'd12,
                                                 4'd2, 4'd7, 4'd15};

  nearest_centroid_classifier_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_slot          (in_slot),
    .in_label         (in_label),
    .in_band          (in_band),
    .in_value         (in_value),
    .in_sample_valid  (in_sample_valid),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_class_label  (out_class_label),
    .out_status       (out_status),
    .out_min_distance (out_min_distance)
  );

  always #6 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** nearest_centroid_classifier_unit: FAILED **");
      $finish;
    end
  end

  // The long output hold-off, counted here while the sender keeps going.
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Effective band count: the register clamped to 1..min(NUM_BANDS, 8).
  function automatic int eff_bands();
    int n;
    n = bands_reg;
    if (n < 1) n = 1;
    if (n > NUM_BANDS) n = NUM_BANDS;
    if (n > 8) n = 8;
    return n;
  endfunction

  // Sample or centroid word, biased toward the extremes and zero.
  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic cls_req_t any_request();
    cls_req_t r;
    r.op = $urandom_range(0, 3);
    r.slot = $urandom;
    r.label = $urandom;
    r.band = $urandom;
    r.value = pick_word();
    r.sample_ok = $urandom;
    return r;
  endfunction

  // Apply one accepted request to the class table and sums, and work out
  // the classification it completes, if any.
  task automatic classify_request(input cls_req_t r, output bit emits,
                                  output class_result_t res);
    int nb;
    int win;
    bit seen;
    longint d;
    longint s;
    longint win_d;
    emits = 1'b0;
    res = '0;
    nb = eff_bands();
    case (r.op)
      OP_WRITE: begin
        centroid[r.slot][r.band] = r.value;
        slot_lbl[r.slot] = r.label;
        slot_used[r.slot] = 1'b1;
      end
      OP_RETIRE: begin
        slot_used[r.slot] = 1'b0;
      end
      OP_SAMPLE: begin
        if (r.band < nb) begin
          // Band 0 opens a new pixel.
          if (r.band == 0) begin
            for (int k = 0; k < NUM_CLASSES; k++) dist_acc[k] = 0;
            pix_bad = 1'b0;
          end
          if (!r.sample_ok) begin
            pix_bad = 1'b1;
          end else begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
              d = longint'($signed(r.value)) - longint'(centroid[k][r.band]);
              s = dist_acc[k] + d * d;
              dist_acc[k] = (s > DIST_SAT) ? DIST_SAT : s;
            end
          end
          // The last band closes the pixel; the nearest used slot wins,
          // and the lowest slot wins a tie.
          if (r.band == nb - 1) begin
            emits = 1'b1;
            seen = 1'b0;
            win = 0;
            win_d = 0;
            if (pix_bad) begin
              res.status = STATUS_BAD_PIX;
            end else begin
              for (int k = 0; k < NUM_CLASSES; k++) begin
                if (slot_used[k] && (!seen || dist_acc[k] < win_d)) begin
                  seen = 1'b1;
                  win = k;
                  win_d = dist_acc[k];
                end
              end
              if (!seen) begin
                res.status = STATUS_NO_CLASS;
              end else begin
                res.status = STATUS_OK;
                res.label = slot_lbl[win];
                res.min_dist = win_d[DIST_W-1:0];
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Offer one request, wait for it to be taken, then predict its result.
  task automatic send_request(input cls_req_t r, input bit typed,
                              input class_result_t typed_res);
    bit emits;
    class_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_op <= r.op;
    in_slot <= r.slot;
    in_label <= r.label;
    in_band <= r.band;
    in_value <= r.value;
    in_sample_valid <= r.sample_ok;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r.op != OP_UNUSED && !(r.op == OP_SAMPLE && r.band >= eff_bands()))
      useful_reqs++;
    classify_request(r, emits, res);
    if (emits) begin
      if (typed) res = typed_res;
      pending_class_q = {pending_class_q, res};
    end else if (typed) begin
      $error("directed row expects a classification that its request cannot complete");
      fail_cnt++;
    end
  endtask

  // Drop valid, wait for every outstanding result and let the chain drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_class_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_bands(input logic [CFG_W-1:0] v);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bands_reg = v;
  endtask

  task automatic add_cfg(input logic [CFG_W-1:0] v);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cfg_val = v;
    dir_q = {dir_q, row};
  endtask

  task automatic add_row(input bit typed, input logic [1:0] op,
                         input logic [SLOT_W-1:0] slot,
                         input logic signed [DATA_W-1:0] label,
                         input logic [BAND_W-1:0] band,
                         input logic signed [DATA_W-1:0] value, input logic ok,
                         input logic signed [DATA_W-1:0] exp_label,
                         input logic [STAT_W-1:0] exp_status,
                         input logic [DIST_W-1:0] exp_dist);
    dir_row_t row;
    row = '0;
    row.req.op = op;
    row.req.slot = slot;
    row.req.label = label;
    row.req.band = band;
    row.req.value = value;
    row.req.sample_ok = ok;
    row.typed = typed;
    row.res.label = exp_label;
    row.res.status = exp_status;
    row.res.min_dist = exp_dist;
    dir_q = {dir_q, row};
  endtask

  // Result side: check each taken classification and pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_class_q.size() == 0) begin
        $error("unexpected classification: label %0d status %0d distance %0d",
               out_class_label, out_status, out_min_distance);
        fail_cnt++;
      end else begin
        popped = pending_class_q.pop_front();
        if (out_class_label !== popped.label) begin
          $error("class_label: expected %0d, got %0d", $signed(popped.label),
                 out_class_label);
          fail_cnt++;
        end
        if (out_status !== popped.status) begin
          $error("status: expected %0d, got %0d", popped.status, out_status);
          fail_cnt++;
        end
        if (out_min_distance !== popped.min_dist) begin
          $error("min_distance: expected %0d, got %0d", popped.min_dist,
                 out_min_distance);
          fail_cnt++;
        end
        case (popped.status)
          STATUS_OK:      n_ok++;
          STATUS_BAD_PIX: n_bad++;
          default:        n_none++;
        endcase
      end
    end
    out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Stimulus.
  initial begin
    cls_req_t r;
    dir_row_t row;
    int base;
    int pick;
    int len;
    int src;
    int nb;

    // Reset, with the behavioral state following it.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    bands_reg = BANDS_AT_RESET;
    pix_bad = 1'b0;
    for (int k = 0; k < NUM_CLASSES; k++) begin
      slot_used[k] = 1'b0;
      dist_acc[k] = 0;
    end
    send_idle_pct = 38;
    recv_idle_pct = 83;

    // Fill every centroid element with zero and label each slot with its
    // index, then retire all slots so the table starts empty but defined.
    for (int s = 0; s < NUM_CLASSES; s++) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        r = any_request();
        r.op = OP_WRITE;
        r.slot = s;
        r.band = b;
        r.label = s;
        r.value = '0;
        send_request(r, 1'b0, '0);
      end
    end
    for (int s = 0; s < NUM_CLASSES; s++) begin
      r = any_request();
      r.op = OP_RETIRE;
      r.slot = s;
      send_request(r, 1'b0, '0);
    end

    // Directed table. A register value of zero acts as one band.
    add_cfg(4'd0);
    // An invalid sample outranks an empty table.
    add_row(1, OP_SAMPLE, 0, 0, 0, 0, 1'b0, 0, STATUS_BAD_PIX, '0);
    add_row(1, OP_SAMPLE, 0, 0, 0, 0, 1'b1, 0, STATUS_NO_CLASS, '0);
    add_row(0, OP_WRITE, 15, -32768, 0, 32767, 1'b1, 0, STATUS_OK, '0);
    add_row(0, OP_WRITE, 0, 32767, 0, -32768, 1'b0, 0, STATUS_OK, '0);
    add_row(1, OP_SAMPLE, 0, 0, 0, -32768, 1'b1, 32767, STATUS_OK, '0);
    add_row(1, OP_SAMPLE, 15, -1, 0, 32767, 1'b1, -32768, STATUS_OK, '0);
    add_row(1, OP_SAMPLE, 0, 0, 0, 0, 1'b0, 0, STATUS_BAD_PIX, '0);
    // The unused op code and a sample past the band count change nothing.
    add_row(0, OP_UNUSED, 15, -1, 7, -1, 1'b1, 0, STATUS_OK, '0);
    add_row(0, OP_RETIRE, 0, 0, 0, 0, 1'b0, 0, STATUS_OK, '0);
    add_row(1, OP_SAMPLE, 0, 0, 0, -32768, 1'b1, -32768, STATUS_OK, 35'd4294836225);
    add_row(0, OP_SAMPLE, 0, 0, 7, 0, 1'b1, 0, STATUS_OK, '0);
    // Two slots at the same distance: the lower slot wins.
    add_row(0, OP_WRITE, 3, 300, 0, 32767, 1'b1, 0, STATUS_OK, '0);
    add_row(1, OP_SAMPLE, 0, 0, 0, 32767, 1'b1, 300, STATUS_OK, '0);
    add_row(0, OP_RETIRE, 3, 0, 0, 0, 1'b0, 0, STATUS_OK, '0);
    // Register above the limit acts as eight bands. A pixel with band 1
    // repeated saturates the sum, and a label rewritten mid-pixel is the one
    // reported.
    add_cfg(4'd15);
    add_row(0, OP_WRITE, 15, -32768, 1, 32767, 1'b1, 0, STATUS_OK, '0);
    add_row(0, OP_SAMPLE, 0, 0, 0, -32768, 1'b1, 0, STATUS_OK, '0);
    for (int i = 0; i < 8; i++)
      add_row(0, OP_SAMPLE, 0, 0, 1, -32768, 1'b1, 0, STATUS_OK, '0);
    add_row(0, OP_WRITE, 15, 1234, 5, 0, 1'b1, 0, STATUS_OK, '0);
    add_row(1, OP_SAMPLE, 0, 0, 7, -32768, 1'b1, 1234, STATUS_OK, 35'h7_FFFF_FFFF);

    foreach (dir_q[i]) begin
      row = dir_q[i];
      if (row.is_cfg) begin
        settle();
        write_bands(row.cfg_val);
      end else begin
        send_request(row.req, row.typed, row.res);
      end
    end

    // Random phases, one band count each, with the idling pattern changing
    // every three phases.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_bands(phase_bands[p]);
      if (p < 3) begin
        send_idle_pct = 38;
        recv_idle_pct = 83;
      end else if (p < 6) begin
        send_idle_pct = 83;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 6) hold_go = 1'b1;
      nb = eff_bands();
      base = useful_reqs;
      while (useful_reqs - base < PHASE_REQS) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // A complete pixel, bands in order, now and then a bad sample.
          for (int b = 0; b < nb; b++) begin
            r = any_request();
            r.op = OP_SAMPLE;
            r.band = b;
            r.sample_ok = ($urandom_range(0, 19) != 0);
            send_request(r, 1'b0, '0);
          end
        end else if (pick < 65) begin
          // A broken pixel: random bands, repeats, gaps and strays.
          len = $urandom_range(1, 2 * nb);
          for (int i = 0; i < len; i++) begin
            r = any_request();
            r.op = OP_SAMPLE;
            send_request(r, 1'b0, '0);
          end
        end else if (pick < 80) begin
          // A few centroid elements.
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++) begin
            r = any_request();
            r.op = OP_WRITE;
            send_request(r, 1'b0, '0);
          end
        end else if (pick < 85) begin
          // Copy one slot's vector into another to provoke ties.
          src = $urandom_range(0, NUM_CLASSES - 1);
          r = any_request();
          r.op = OP_WRITE;
          for (int b = 0; b < NUM_BANDS; b++) begin
            r.band = b;
            r.value = centroid[src][b];
            send_request(r, 1'b0, '0);
          end
        end else if (pick < 92) begin
          r = any_request();
          r.op = OP_RETIRE;
          send_request(r, 1'b0, '0);
        end else if (pick < 96) begin
          r = any_request();
          r.op = OP_UNUSED;
          send_request(r, 1'b0, '0);
        end else begin
          send_request(any_request(), 1'b0, '0);
        end
      end
    end

    settle();
    $display("Checked %0d classifications (%0d labeled, %0d invalid pixel, %0d no class)",
             n_ok + n_bad + n_none, n_ok, n_bad, n_none);
    $display("from %0d effective requests over %0d band counts, with a %0d-cycle hold-off.",
             useful_reqs, NUM_PHASES + 2, HOLD_CYCLES);
    if (fail_cnt == 0) begin
      $display("** nearest_centroid_classifier_unit: PASSED **");
    end else begin
      $display("** nearest_centroid_classifier_unit: FAILED **");
    end
    $finish;
  end

endmodule
